/* rtl/core/mexp_pkg.sv */
// shared constants and controller/datapath types for the modular exponentiation block
// no dependencies

package mexp_pkg;

  localparam int MOD_BITS = 32;
  localparam int EXP_BITS = 32;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(MOD_BITS);
  localparam int ADDR_W   = 3;

  localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(1000003);

  // register word index (paddr[2])
  localparam logic REG_MODULUS = 1'b0;

  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_step;
    logic start_mul;
    logic start_sqr;
    logic wr_sq;
    logic wr_acc;
    logic exp_clr0;
    logic exp_shift;
    logic cap_out;
  } mexp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_bit0;
  } mexp_stat_t;

endpackage

/* rtl/core/mexp_if.sv */
// request and result channel interfaces for the modular exponentiation block
// depends on mexp_pkg

interface mexp_req_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::DATA_W-1:0]  base_value;
  logic [mexp_pkg::DATA_W-1:0]  exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_res_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::DATA_W-1:0]  power_result;

  modport source (output valid, output power_result, input ready);
  modport sink (input valid, input power_result, output ready);
endinterface

/* rtl/core/mexp_datapath.sv */
// datapath: operand registers, shared shift-add modular step unit, result register
// depends on mexp_pkg

module mexp_datapath (
  input  logic                          clk,
  input  mexp_pkg::mexp_cmd_t           cmd,
  input  logic [mexp_pkg::DATA_W-1:0]   base_value,
  input  logic [mexp_pkg::DATA_W-1:0]   exponent,
  input  logic [mexp_pkg::DATA_W-1:0]   modulus,
  output mexp_pkg::mexp_stat_t          stat,
  output logic [mexp_pkg::DATA_W-1:0]   power_result
);

  localparam int MB = mexp_pkg::MOD_BITS;
  localparam int EB = mexp_pkg::EXP_BITS;

  logic [MB-1:0] mod_r;
  logic [MB-1:0] base_sh;
  logic [EB-1:0] exp_sh;
  logic [MB-1:0] acc;
  logic [MB-1:0] sq;
  logic [MB-1:0] part;
  logic [MB-1:0] mcand;
  logic [MB-1:0] mplier;
  logic [mexp_pkg::DATA_W-1:0] res;

  logic [MB-1:0] addend;
  logic [MB+1:0] t;
  logic [MB+1:0] mod_ext;
  logic [MB+1:0] mod2_ext;
  logic [MB+1:0] t_m1;
  logic [MB+1:0] t_m2;
  logic [MB-1:0] step_out;
  logic [MB-1:0] mod_in;
  logic [EB-1:0] exp_in;

  assign mod_in = MB'(modulus);
  assign exp_in = EB'(exponent);

  // one bit of a shift-add product (or of a base reduction): 2*part + addend, reduced
  always_comb begin
    if (cmd.red_step) begin
      addend = {{(MB-1){1'b0}}, base_sh[MB-1]};
    end else if (mplier[MB-1]) begin
      addend = mcand;
    end else begin
      addend = '0;
    end
    t        = {1'b0, part, 1'b0} + {2'b00, addend};
    mod_ext  = {2'b00, mod_r};
    mod2_ext = {1'b0, mod_r, 1'b0};
    t_m1     = t - mod_ext;
    t_m2     = t - mod2_ext;
    if (mod_r == '0) begin
      step_out = t[MB-1:0];            // zero modulus wraps at the field width
    end else if (t >= mod2_ext) begin
      step_out = t_m2[MB-1:0];
    end else if (t >= mod_ext) begin
      step_out = t_m1[MB-1:0];
    end else begin
      step_out = t[MB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r   <= mod_in;
      base_sh <= MB'(base_value);
      exp_sh  <= exp_in;
      part    <= '0;
      // zero exponent gives exactly one, else one reduced by the modulus
      if (exp_in == '0 || mod_in != MB'(1)) begin
        acc <= MB'(1);
      end else begin
        acc <= '0;
      end
    end
    if (cmd.red_step) begin
      part    <= step_out;
      base_sh <= base_sh << 1;
    end
    if (cmd.mul_step) begin
      part   <= step_out;
      mplier <= mplier << 1;
    end
    if (cmd.start_mul) begin
      part   <= '0;
      mcand  <= acc;
      mplier <= sq;
    end
    if (cmd.start_sqr) begin
      part   <= '0;
      mcand  <= sq;
      mplier <= sq;
    end
    if (cmd.wr_sq) begin
      sq <= step_out;
    end
    if (cmd.wr_acc) begin
      acc <= step_out;
    end
    if (cmd.exp_clr0) begin
      exp_sh[0] <= 1'b0;
    end
    if (cmd.exp_shift) begin
      exp_sh <= exp_sh >> 1;
    end
    if (cmd.cap_out) begin
      res <= mexp_pkg::DATA_W'(acc);
    end
  end

  assign stat.exp_zero = (exp_sh == '0);
  assign stat.exp_bit0 = exp_sh[0];
  assign power_result  = res;

endmodule

/* rtl/core/mexp_ctrl.sv */
// controller: sequences base reduction, multiplies and squarings, owns the handshakes
// depends on mexp_pkg

module mexp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  output logic                  res_valid,
  input  logic                  res_ready,
  input  mexp_pkg::mexp_stat_t  stat,
  output mexp_pkg::mexp_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SQR    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam logic [mexp_pkg::CNT_W-1:0] CNT_LAST = mexp_pkg::CNT_W'(mexp_pkg::MOD_BITS - 1);

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [mexp_pkg::CNT_W-1:0] cnt;
  logic [mexp_pkg::CNT_W-1:0] cnt_next;
  logic                       out_valid;
  logic                       out_valid_next;
  logic                       last;

  assign last = (cnt == CNT_LAST);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.red_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last) begin
          cmd.wr_sq  = 1'b1;
          cnt_next   = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.exp_zero) begin
          state_next = S_FINISH;
        end else if (stat.exp_bit0) begin
          cmd.start_mul = 1'b1;
          state_next    = S_MUL;
        end else begin
          cmd.start_sqr = 1'b1;
          state_next    = S_SQR;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last) begin
          cmd.wr_acc   = 1'b1;
          cmd.exp_clr0 = 1'b1;
          cnt_next     = '0;
          state_next   = S_CHECK;
        end
      end
      S_SQR: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (last) begin
          cmd.wr_sq     = 1'b1;
          cmd.exp_shift = 1'b1;
          cnt_next      = '0;
          state_next    = S_CHECK;
        end
      end
      S_FINISH: begin
        if (!out_valid || res_ready) begin
          cmd.cap_out = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.cap_out) begin
      out_valid_next = 1'b1;
    end else if (res_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign res_valid = out_valid;

endmodule

/* rtl/core/modular_exponentiation.sv */
// top level of the modular exponentiation block: apb modulus register, controller, datapath
// depends on mexp_pkg, mexp_if, mexp_ctrl, mexp_datapath
//
// usage
//   request channel (valid/ready) carries base_value and exponent; result channel
//   carries power_result = base_value ** exponent mod modulus, exactly 1 for a
//   zero exponent. modulus is written over the apb port at byte address 0 and
//   reads back there; reset value 1000003, zero means plain wrap at 32 bits.
//   only write the modulus while no request is in flight.
// sequence
//   one request at a time. the base is first reduced, then each exponent bit
//   up to the top set bit costs one shift-add multiply per squaring and per
//   set bit, plus one decision step each; a zero exponent goes straight from
//   the reduction to the result. the shared modular step unit in the datapath
//   handles one bit per cycle for the reduction and for every multiply.
// reset
//   synchronous active-high rst empties the result register and returns the
//   controller to idle; the modulus goes back to its reset value.
// stall
//   the result sits in an output register; a new request is taken once the
//   previous one has moved into it, and a finished computation waits until the
//   output register is free.

module modular_exponentiation (
  input  logic                          clk,
  input  logic                          rst,
  mexp_req_if.sink                      request,
  mexp_res_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [mexp_pkg::DATA_W-1:0] modulus;
  logic                        reg_wr;
  mexp_pkg::mexp_cmd_t         cmd;
  mexp_pkg::mexp_stat_t        stat;
  logic [mexp_pkg::DATA_W-1:0] power_result;

  // apb: zero wait states, word index in paddr[2]
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == mexp_pkg::REG_MODULUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::MODULUS_RESET;
    end else if (reg_wr) begin
      modulus <= mexp_pkg::DATA_W'(pwdata);
    end
  end

  always_comb begin
    if (paddr[2] == mexp_pkg::REG_MODULUS) begin
      prdata = 32'(modulus);
    end else begin
      prdata = '0;
    end
  end

  // sequencing of reduce / multiply / square steps and both handshakes
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // operand registers and the shared modular step unit
  mexp_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .base_value   (request.base_value),
    .exponent     (request.exponent),
    .modulus      (modulus),
    .stat         (stat),
    .power_result (power_result)
  );

  assign result.power_result = power_result;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for modular_exponentiation: random and directed power requests
// depends on mexp_pkg, mexp_req_if, mexp_res_if and the modular_exponentiation rtl

module tb;

  // fewer than 300 requests are queued, so this leaves several times the
  // worst-case run of all of them including output stalls
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam logic [63:0] WRAP_MASK   = (64'd1 << mexp_pkg::MOD_BITS) - 64'd1;

  typedef struct {
    logic [mexp_pkg::DATA_W-1:0] base_value;
    logic [mexp_pkg::DATA_W-1:0] exponent;
  } power_request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, driven from the tb and forwarded into the interface
  logic                        req_valid    = 1'b0;
  logic [mexp_pkg::DATA_W-1:0] req_base     = '0;
  logic [mexp_pkg::DATA_W-1:0] req_exponent = '0;
  logic                        res_ready    = 1'b0;

  // apb side
  logic                        psel    = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite  = 1'b0;
  logic [mexp_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                 pwdata  = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  mexp_req_if request_ch ();
  mexp_res_if result_ch ();

  assign request_ch.valid      = req_valid;
  assign request_ch.base_value = req_base;
  assign request_ch.exponent   = req_exponent;
  assign result_ch.ready       = res_ready;

  modular_exponentiation dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // requests waiting to be driven, and powers waiting to come back
  power_request_t              pending_q[$];
  logic [mexp_pkg::DATA_W-1:0] power_expect_q[$];
  power_request_t              next_req;

  logic [mexp_pkg::DATA_W-1:0] modulus_now = mexp_pkg::MODULUS_RESET;  // tb copy of the register
  logic                        calm        = 1'b0;  // disables idling on both sides
  int unsigned                 n_queued    = 0;
  int unsigned                 n_accepted  = 0;
  int unsigned                 err_cnt     = 0;
  int unsigned                 cycle_cnt   = 0;

  // x mod m, with m == 0 meaning plain wrap at MOD_BITS
  function automatic logic [63:0] mod_reduce(input logic [63:0] x,
                                             input logic [mexp_pkg::DATA_W-1:0] m);
    if (m == '0) return x & WRAP_MASK;
    return x % {32'd0, m};
  endfunction

  // square and multiply, lsb first; operands stay below 2^32 so the
  // full product fits in 64 bits before reduction
  function automatic logic [mexp_pkg::DATA_W-1:0] modexp_predict(
      input logic [mexp_pkg::DATA_W-1:0] base,
      input logic [mexp_pkg::DATA_W-1:0] power,
      input logic [mexp_pkg::DATA_W-1:0] m);
    logic [63:0] sq;
    logic [63:0] acc;
    if (power == '0) return mexp_pkg::DATA_W'(1);  // zero exponent is exactly one, even mod 1
    sq  = mod_reduce({32'd0, base}, m);
    acc = mod_reduce(64'd1, m);
    for (int i = 0; i < mexp_pkg::EXP_BITS; i++) begin
      if (power[i]) acc = mod_reduce(acc * sq, m);
      sq = mod_reduce(sq * sq, m);
    end
    return acc[mexp_pkg::DATA_W-1:0];
  endfunction

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // request driver: keeps the payload stable until it is taken, predicts the
  // power at the accepting edge with the modulus in force at that time
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && request_ch.ready) begin
        power_expect_q.insert(power_expect_q.size(),
                              modexp_predict(req_base, req_exponent, modulus_now));
        n_accepted++;
      end
      if (!req_valid || request_ch.ready) begin
        // about one idle slot in ten unless a calm phase is running
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          next_req = pending_q.pop_front();
          req_valid    <= 1'b1;
          req_base     <= next_req.base_value;
          req_exponent <= next_req.exponent;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted power with the oldest prediction,
  // and stalls the output register at random
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (result_ch.valid && res_ready) begin
        if (power_expect_q.size() == 0) begin
          $error("power_result: expected none, actual %h", result_ch.power_result);
          err_cnt++;
        end else if (result_ch.power_result !== power_expect_q[0]) begin
          $error("power_result: expected %h, actual %h", power_expect_q[0],
                 result_ch.power_result);
          err_cnt++;
          void'(power_expect_q.pop_front());
        end else begin
          void'(power_expect_q.pop_front());
        end
      end
      res_ready <= calm || ($urandom_range(99) >= 10);
    end
  end

  task automatic queue_request(input logic [mexp_pkg::DATA_W-1:0] base,
                               input logic [mexp_pkg::DATA_W-1:0] power);
    power_request_t req_item;
    req_item.base_value = base;
    req_item.exponent   = power;
    pending_q.insert(pending_q.size(), req_item);
    n_queued++;
  endtask

  // block until every queued request is taken and every power has come back;
  // polled at the falling edge so all clocked updates have settled
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || power_expect_q.size() != 0);
  endtask

  // one apb transfer: setup cycle, then access until pready
  task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {mexp_pkg::REG_MODULUS, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write the modulus while idle, then read it back
  task automatic program_modulus(input logic [mexp_pkg::DATA_W-1:0] value);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, value, rd);
    modulus_now = value;
    apb_access(1'b0, '0, rd);
    if (rd !== value) begin
      $error("modulus: expected %h, actual %h", value, rd);
      err_cnt++;
    end
  endtask

  // stimulus
  initial begin
    logic [31:0]                 rd;
    logic [mexp_pkg::DATA_W-1:0] mod_pick;
    logic [mexp_pkg::DATA_W-1:0] b;
    logic [mexp_pkg::DATA_W-1:0] e;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset value of the modulus must read back
    apb_access(1'b0, '0, rd);
    if (rd !== mexp_pkg::MODULUS_RESET) begin
      $error("modulus: expected %h, actual %h", mexp_pkg::MODULUS_RESET, rd);
      err_cnt++;
    end

    // directed: reset modulus, field extremes, unreduced bases
    queue_request(32'h0000_0000, 32'h0000_0000);
    queue_request(32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(32'h0000_0000, 32'h0000_0001);
    queue_request(32'hFFFF_FFFF, 32'h0000_0001);
    queue_request(32'h0000_0002, 32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(mexp_pkg::MODULUS_RESET, 32'h0000_0005);      // base equal to modulus
    queue_request(mexp_pkg::MODULUS_RESET + 1, 32'h0000_0003);  // base just above modulus
    queue_request(32'h0000_3039, 32'h8000_0000);                // only top exponent bit
    queue_request(32'h0000_0003, 32'h0000_0002);

    // modulus one: zero for any nonzero exponent, one for a zero exponent
    program_modulus(32'd1);
    queue_request(32'h0000_0007, 32'h0000_0000);
    queue_request(32'h0000_0007, 32'h0000_0005);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // largest modulus: products need the full 64-bit width
    program_modulus(32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFF, 32'h0000_0003);          // base reduces to zero
    queue_request(32'hFFFF_FFFE, 32'h0000_0002);

    // modulus zero: plain wrap at 32 bits
    program_modulus(32'd0);
    queue_request(32'h0000_0003, 32'h0000_0028);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(32'h0000_0002, 32'h0000_0020);          // wraps to zero
    queue_request(32'h0000_0000, 32'h0000_0000);

    // smallest useful modulus
    program_modulus(32'd2);
    queue_request(32'h0000_0005, 32'h0000_0007);
    queue_request(32'h0000_0004, 32'h0000_0001);

    // random phases, each under its own modulus; one runs with no idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: mod_pick = $urandom();
        1: mod_pick = $urandom_range(1000, 2);
        2: mod_pick = 32'h8000_0000 | $urandom();
        3: mod_pick = 32'hFFFF_FFFF;
        4: mod_pick = 32'd0;
        5: mod_pick = mexp_pkg::MODULUS_RESET;
        6: mod_pick = $urandom() | 32'd1;
        default: mod_pick = 32'd1;
      endcase
      program_modulus(mod_pick);
      calm = (ph == 3);
      for (int k = 0; k < 33; k++) begin
        case ($urandom_range(3))
          0: b = $urandom_range(15);
          1: b = modulus_now + $urandom_range(3);
          2: b = 32'hFFFF_FFFF - $urandom_range(3);
          default: b = $urandom();
        endcase
        case ($urandom_range(5))
          0: e = $urandom_range(64);
          1: e = 32'd1 << $urandom_range(31);
          2: e = 32'hFFFF_FFFF >> $urandom_range(31);
          default: e = $urandom();
        endcase
        queue_request(b, e);
      end
    end

    // drain, give the block time to show any stray result, then report
    wait_drained();
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
